// ===== hw/rtl/rjde_pkg.sv =====
// Shared types, constants and register codes for the RTP jitter delay estimator.
package rjde_pkg;

  localparam int unsigned TS_W       = 32;
  localparam int unsigned TICKS_W    = 8;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned AVG_W      = 32;
  localparam int unsigned PROD_W     = 26;
  localparam int unsigned IVL_W      = 6;
  localparam int unsigned IVL_RAW_W  = 16;
  localparam int unsigned DELAY_W    = 17;
  localparam int unsigned MS_W       = 23;

  localparam int unsigned DIV_W      = 36;
  localparam int unsigned DIVISOR_W  = 10;
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_ITERS  = DIV_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_ITERS);

  localparam logic [CFG_IDX_W-1:0] REG_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODEC = 2'd2;

  localparam logic [TICKS_W-1:0] TICKS_RESET = 8'd8;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd20000;
  localparam logic [IVL_W-1:0]   IVL_RESET   = 6'd20;
  localparam logic [IVL_W-1:0]   IVL_MIN     = 6'd10;
  localparam logic [IVL_W-1:0]   IVL_MAX     = 6'd60;

  localparam logic [DIVISOR_W-1:0] US_PER_MS  = 10'd1000;
  localparam logic [DIVISOR_W-1:0] HALF_MS_US = 10'd500;
  localparam logic [TS_W-1:0]      HALF_RANGE = 32'h8000_0000;

  typedef enum logic [1:0] {
    DIV_LEAD,
    DIV_INTERVAL,
    DIV_MS
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEAD,
    S_LEAD_WAIT,
    S_INTV,
    S_INTV_WAIT,
    S_PRODUCT,
    S_AVERAGE,
    S_MS,
    S_MS_WAIT,
    S_OUTPUT
  } ctrl_state_t;

  typedef struct packed {
    logic     load_in;
    logic     div_start;
    div_sel_t div_sel;
    logic     take_lead;
    logic     take_interval;
    logic     product;
    logic     write_avg;
    logic     take_ms;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic codec_valid;
    logic div_busy;
    logic div_done;
  } sts_t;

endpackage

// ===== hw/rtl/rjde_in_if.sv =====
// Packet channel carrying the RTP and playout timestamps of one received packet.
interface rjde_in_if;
  logic                      valid;
  logic                      ready;
  logic [rjde_pkg::TS_W-1:0] media_ts;
  logic [rjde_pkg::TS_W-1:0] playout_ts;

  modport source (output valid, output media_ts, output playout_ts, input ready);
  modport sink (input valid, input media_ts, input playout_ts, output ready);
endinterface

// ===== hw/rtl/rjde_out_if.sv =====
// Result channel carrying the delay estimate produced for one packet.
interface rjde_out_if;
  logic                         valid;
  logic                         ready;
  logic                         estimate_valid;
  logic [rjde_pkg::DELAY_W-1:0] jitter_delay_ms;
  logic [rjde_pkg::IVL_W-1:0]   packet_interval_ms;

  modport source (output valid, output estimate_valid, output jitter_delay_ms,
                  output packet_interval_ms, input ready);
  modport sink (input valid, input estimate_valid, input jitter_delay_ms,
                input packet_interval_ms, output ready);
endinterface

// ===== hw/rtl/rjde_divider.sv =====
// Iterative restoring divider that retires four quotient bits per cycle.
module rjde_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rjde_pkg::DIV_W-1:0]     dividend,
  input  logic [rjde_pkg::DIVISOR_W-1:0] divisor,
  output logic                           busy,
  output logic                           done,
  output logic [rjde_pkg::DIV_W-1:0]     quotient
);

  logic [rjde_pkg::DIV_W-1:0]     quo;
  logic [rjde_pkg::DIV_W-1:0]     quo_next;
  logic [rjde_pkg::DIVISOR_W-1:0] rem;
  logic [rjde_pkg::DIVISOR_W-1:0] rem_next;
  logic [rjde_pkg::DIVISOR_W-1:0] dsr;
  logic [rjde_pkg::DIV_CNT_W-1:0] cnt;

  always_comb begin
    logic [rjde_pkg::DIVISOR_W:0] trial;
    quo_next = quo;
    rem_next = rem;
    for (int i = 0; i < rjde_pkg::DIV_STEPS; i++) begin
      trial = {rem_next, quo_next[rjde_pkg::DIV_W-1]};
      if (trial >= {1'b0, dsr}) begin
        rem_next = rjde_pkg::DIVISOR_W'(trial - {1'b0, dsr});
        quo_next = {quo_next[rjde_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_next = trial[rjde_pkg::DIVISOR_W-1:0];
        quo_next = {quo_next[rjde_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == rjde_pkg::DIV_CNT_W'(rjde_pkg::DIV_ITERS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("Divider done held for more than one cycle.");
  a_start_runs: assert property (@(posedge clk) disable iff (rst) start |=> busy && !done)
    else $error("Divider did not begin after start.");

endmodule

// ===== hw/rtl/rjde_datapath.sv =====
// Datapath: configuration, estimator state, shared divider and result payload.
module rjde_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [rjde_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [rjde_pkg::CFG_DATA_W-1:0] wr_data,
  input  logic [rjde_pkg::TS_W-1:0]       media_ts,
  input  logic [rjde_pkg::TS_W-1:0]       playout_ts,
  input  rjde_pkg::cmd_t                  cmd,
  output rjde_pkg::sts_t                  sts,
  output logic                            estimate_valid,
  output logic [rjde_pkg::DELAY_W-1:0]    jitter_delay_ms,
  output logic [rjde_pkg::IVL_W-1:0]      packet_interval_ms
);

  logic [rjde_pkg::TICKS_W-1:0]   ticks;
  logic [rjde_pkg::LIMIT_W-1:0]   lead_limit;
  logic                           codec_valid;

  logic [rjde_pkg::TS_W-1:0]      rtp;
  logic [rjde_pkg::TS_W-1:0]      play;
  logic [rjde_pkg::TS_W-1:0]      prev_rtp;
  logic [rjde_pkg::AVG_W-1:0]     avg;
  logic [rjde_pkg::IVL_W-1:0]     stored_ivl;
  logic [rjde_pkg::LIMIT_W-1:0]   lead;
  logic [rjde_pkg::IVL_RAW_W-1:0] interval;
  logic [rjde_pkg::PROD_W-1:0]    product;
  logic [rjde_pkg::MS_W-1:0]      ms;

  logic [rjde_pkg::TS_W-1:0]      lead_diff;
  logic [rjde_pkg::TS_W-1:0]      ivl_diff;
  logic                           newer;
  logic                           lead_ok;
  logic                           ivl_in_range;
  logic [rjde_pkg::AVG_W+2:0]     avg_sum;
  logic [rjde_pkg::AVG_W:0]       avg_round;
  logic [rjde_pkg::MS_W-1:0]      delay_sum;

  logic                           div_start;
  logic [rjde_pkg::DIV_W-1:0]     div_dividend;
  logic [rjde_pkg::DIVISOR_W-1:0] div_divisor;
  logic [rjde_pkg::DIVISOR_W-1:0] ticks_div;
  logic                           div_busy;
  logic                           div_done;
  logic [rjde_pkg::DIV_W-1:0]     div_quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks       <= rjde_pkg::TICKS_RESET;
      lead_limit  <= rjde_pkg::LIMIT_RESET;
      codec_valid <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        rjde_pkg::REG_TICKS: ticks       <= wr_data[rjde_pkg::TICKS_W-1:0];
        rjde_pkg::REG_LIMIT: lead_limit  <= wr_data[rjde_pkg::LIMIT_W-1:0];
        rjde_pkg::REG_CODEC: codec_valid <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign lead_diff = rtp - play;
  assign ivl_diff  = rtp - prev_rtp;
  assign newer     = (lead_diff == rjde_pkg::HALF_RANGE) ? (rtp > play)
                   : ((lead_diff != '0) && !lead_diff[rjde_pkg::TS_W-1]);
  assign lead_ok   = newer &&
                     (div_quotient[rjde_pkg::TS_W-1:0] <= rjde_pkg::TS_W'(lead_limit));
  assign ivl_in_range = (interval >= rjde_pkg::IVL_RAW_W'(rjde_pkg::IVL_MIN)) &&
                        (interval <= rjde_pkg::IVL_RAW_W'(rjde_pkg::IVL_MAX));

  // Weighted update: (7 * avg + new sample + 500) / 8.
  assign avg_sum = ({avg, 3'b000} - {3'b000, avg}) + (rjde_pkg::AVG_W + 3)'(product)
                 + (rjde_pkg::AVG_W + 3)'(rjde_pkg::HALF_MS_US);
  assign avg_round = {1'b0, avg} + (rjde_pkg::AVG_W + 1)'(rjde_pkg::HALF_MS_US);

  assign ticks_div = (ticks == '0) ? rjde_pkg::DIVISOR_W'(1)
                                   : rjde_pkg::DIVISOR_W'(ticks);

  always_comb begin
    div_dividend = rjde_pkg::DIV_W'(avg_round);
    div_divisor  = rjde_pkg::US_PER_MS;
    case (cmd.div_sel)
      rjde_pkg::DIV_LEAD: begin
        div_dividend = rjde_pkg::DIV_W'(lead_diff);
        div_divisor  = ticks_div;
      end
      rjde_pkg::DIV_INTERVAL: begin
        div_dividend = rjde_pkg::DIV_W'(ivl_diff);
        div_divisor  = ticks_div;
      end
      rjde_pkg::DIV_MS: begin
        div_dividend = rjde_pkg::DIV_W'(avg_round);
        div_divisor  = rjde_pkg::US_PER_MS;
      end
      default: ;
    endcase
  end

  assign div_start = cmd.div_start;

  rjde_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_rtp   <= '0;
      avg        <= '0;
      stored_ivl <= rjde_pkg::IVL_RESET;
    end else begin
      if (cmd.take_interval) begin
        prev_rtp <= rtp;
      end
      if (cmd.product && (lead != '0) && ivl_in_range) begin
        stored_ivl <= interval[rjde_pkg::IVL_W-1:0];
      end
      if (cmd.write_avg && (lead != '0)) begin
        avg <= (avg == '0) ? rjde_pkg::AVG_W'(product) : avg_sum[rjde_pkg::AVG_W+2:3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rtp  <= media_ts;
      play <= playout_ts;
    end
    if (cmd.take_lead) begin
      lead <= lead_ok ? div_quotient[rjde_pkg::LIMIT_W-1:0] : '0;
    end
    if (cmd.take_interval) begin
      interval <= div_quotient[rjde_pkg::IVL_RAW_W-1:0];
    end
    if (cmd.product) begin
      product <= rjde_pkg::PROD_W'(lead) * rjde_pkg::PROD_W'(rjde_pkg::US_PER_MS);
    end
    if (cmd.take_ms) begin
      ms <= div_quotient[rjde_pkg::MS_W-1:0];
    end
  end

  assign delay_sum = ms + rjde_pkg::MS_W'(stored_ivl);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      estimate_valid     <= (avg != '0);
      jitter_delay_ms    <= (avg != '0) ? delay_sum[rjde_pkg::DELAY_W-1:0] : '0;
      packet_interval_ms <= stored_ivl;
    end
  end

  assign sts.codec_valid = codec_valid;
  assign sts.div_busy    = div_busy;
  assign sts.div_done    = div_done;

endmodule

// ===== hw/rtl/rjde_ctrl.sv =====
// Controller state machine that sequences one packet through the datapath.
module rjde_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  rjde_pkg::sts_t sts,
  output rjde_pkg::cmd_t cmd
);

  rjde_pkg::ctrl_state_t state;
  rjde_pkg::ctrl_state_t state_next;
  logic                  in_fire;
  logic                  out_free;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rjde_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rjde_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = sts.codec_valid ? rjde_pkg::S_LEAD : rjde_pkg::S_MS;
        end
      end
      rjde_pkg::S_LEAD:      state_next = rjde_pkg::S_LEAD_WAIT;
      rjde_pkg::S_LEAD_WAIT: if (sts.div_done) state_next = rjde_pkg::S_INTV;
      rjde_pkg::S_INTV:      state_next = rjde_pkg::S_INTV_WAIT;
      rjde_pkg::S_INTV_WAIT: if (sts.div_done) state_next = rjde_pkg::S_PRODUCT;
      rjde_pkg::S_PRODUCT:   state_next = rjde_pkg::S_AVERAGE;
      rjde_pkg::S_AVERAGE:   state_next = rjde_pkg::S_MS;
      rjde_pkg::S_MS:        state_next = rjde_pkg::S_MS_WAIT;
      rjde_pkg::S_MS_WAIT:   if (sts.div_done) state_next = rjde_pkg::S_OUTPUT;
      rjde_pkg::S_OUTPUT:    if (out_free) state_next = rjde_pkg::S_IDLE;
      default:               state_next = rjde_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.div_sel = rjde_pkg::DIV_MS;
    in_ready = 1'b0;
    case (state)
      rjde_pkg::S_IDLE: begin
        in_ready    = !rst;
        cmd.load_in = in_valid;
      end
      rjde_pkg::S_LEAD: begin
        cmd.div_sel   = rjde_pkg::DIV_LEAD;
        cmd.div_start = 1'b1;
      end
      rjde_pkg::S_LEAD_WAIT: cmd.take_lead = sts.div_done;
      rjde_pkg::S_INTV: begin
        cmd.div_sel   = rjde_pkg::DIV_INTERVAL;
        cmd.div_start = 1'b1;
      end
      rjde_pkg::S_INTV_WAIT: cmd.take_interval = sts.div_done;
      rjde_pkg::S_PRODUCT:   cmd.product = 1'b1;
      rjde_pkg::S_AVERAGE:   cmd.write_avg = 1'b1;
      rjde_pkg::S_MS: begin
        cmd.div_sel   = rjde_pkg::DIV_MS;
        cmd.div_start = 1'b1;
      end
      rjde_pkg::S_MS_WAIT:   cmd.take_ms = sts.div_done;
      rjde_pkg::S_OUTPUT:    cmd.load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_start_idle_div: assert property (@(posedge clk) disable iff (rst)
                                     cmd.div_start |-> !sts.div_busy)
    else $error("Divider started while still busy.");
  a_load_free_slot: assert property (@(posedge clk) disable iff (rst)
                                     cmd.load_out |-> (!out_valid || out_ready))
    else $error("Result register overwritten before its beat was taken.");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
                                    in_fire |=> !in_ready && !cmd.load_out)
    else $error("Packet accepted while another is in flight.");

endmodule

// ===== hw/rtl/rtp_jitter_delay_estimator.sv =====
// Top level of the RTP jitter delay estimator.
// With a codec registered, the packet makes three passes through one shared divider that
// retires four quotient bits per cycle, for the timestamp lead, the packet interval and the
// conversion of the averaged delay to ms. Each pass starts the divider, lets it divide and
// then takes the quotient, and the product, average and output steps come on top of the
// passes. With no codec registered the first two passes and the update steps are skipped.
// One packet is processed at a time, so a new packet is accepted only after the last one has
// reached its output step. The finished result sits in an output register, so the next
// packet is accepted while that result beat waits; a waiting result stalls only the output
// step of the following packet. Configuration writes take effect at once and belong
// between packets.
module rtp_jitter_delay_estimator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [rjde_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [rjde_pkg::CFG_DATA_W-1:0] wr_data,
  rjde_in_if.sink                         packet,
  rjde_out_if.source                      result
);

  rjde_pkg::cmd_t cmd;
  rjde_pkg::sts_t sts;

  rjde_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (packet.valid),
    .in_ready  (packet.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rjde_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .wr_en              (wr_en),
    .wr_index           (wr_index),
    .wr_data            (wr_data),
    .media_ts           (packet.media_ts),
    .playout_ts         (packet.playout_ts),
    .cmd                (cmd),
    .sts                (sts),
    .estimate_valid     (result.estimate_valid),
    .jitter_delay_ms    (result.jitter_delay_ms),
    .packet_interval_ms (result.packet_interval_ms)
  );

endmodule

// ===== sim/tb_rtp_jitter_delay_estimator.sv =====
// Self-checking testbench for the RTP jitter delay estimator, with a delay scoreboard.
`timescale 1ns / 100ps

module tb_rtp_jitter_delay_estimator;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [rjde_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic                         estimate_valid;
    logic [rjde_pkg::DELAY_W-1:0] jitter_delay_ms;
    logic [rjde_pkg::IVL_W-1:0]   packet_interval_ms;
  } delay_result_t;

  class delay_scoreboard;
    logic [rjde_pkg::TICKS_W-1:0] ticks_per_ms;
    logic [rjde_pkg::LIMIT_W-1:0] lead_limit;
    logic                         codec_on;
    logic [rjde_pkg::AVG_W-1:0]   avg_us;
    logic [rjde_pkg::TS_W-1:0]    last_rtp;
    logic [rjde_pkg::IVL_W-1:0]   kept_interval;
    delay_result_t                pending_delays[$];
    int                           errors;

    function new();
      ticks_per_ms  = rjde_pkg::TICKS_RESET;
      lead_limit    = rjde_pkg::LIMIT_RESET;
      codec_on      = 1'b0;
      avg_us        = '0;
      last_rtp      = '0;
      kept_interval = rjde_pkg::IVL_RESET;
      errors        = 0;
    endfunction

    task report(input string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function void write_reg(input logic [rjde_pkg::CFG_IDX_W-1:0]  idx,
                            input logic [rjde_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        rjde_pkg::REG_TICKS: ticks_per_ms = data[rjde_pkg::TICKS_W-1:0];
        rjde_pkg::REG_LIMIT: lead_limit = data[rjde_pkg::LIMIT_W-1:0];
        rjde_pkg::REG_CODEC: codec_on = data[0];
        default: ;
      endcase
    endfunction

    function void note_packet(input logic [rjde_pkg::TS_W-1:0] rtp,
                              input logic [rjde_pkg::TS_W-1:0] play);
      logic [31:0]   ticks;
      logic [31:0]   diff;
      logic [31:0]   lead;
      logic [31:0]   gap;
      logic [15:0]   ivl;
      logic          newer;
      logic [63:0]   acc;
      delay_result_t r;
      if (codec_on) begin
        ticks = (ticks_per_ms == 0) ? 32'd1 : {24'd0, ticks_per_ms};
        diff = rtp - play;
        if (diff == rjde_pkg::HALF_RANGE) begin
          newer = rtp > play;
        end else begin
          newer = (diff != 0) && (diff < rjde_pkg::HALF_RANGE);
        end
        lead = diff / ticks;
        if (!newer || lead > {16'd0, lead_limit}) begin
          lead = '0;
        end
        gap = (rtp - last_rtp) / ticks;
        ivl = gap[15:0];
        last_rtp = rtp;
        if (lead != 0) begin
          if (ivl >= rjde_pkg::IVL_MIN && ivl <= rjde_pkg::IVL_MAX) begin
            kept_interval = ivl[rjde_pkg::IVL_W-1:0];
          end
          if (avg_us == 0) begin
            avg_us = lead * 32'd1000;
          end else begin
            acc = 64'(avg_us) * 64'd7 + 64'(lead) * 64'd1000 + 64'd500;
            avg_us = acc[34:3];
          end
        end
      end
      r.estimate_valid = (avg_us != 0);
      acc = (64'(avg_us) + 64'd500) / 64'd1000 + 64'(kept_interval);
      r.jitter_delay_ms = r.estimate_valid ? acc[rjde_pkg::DELAY_W-1:0] : '0;
      r.packet_interval_ms = kept_interval;
      pending_delays.push_back(r);
    endfunction

    task check_result(input delay_result_t got);
      delay_result_t exp_r;
      if (pending_delays.size() == 0) begin
        report("result beat with no packet outstanding");
      end else begin
        exp_r = pending_delays.pop_front();
        if (got.estimate_valid !== exp_r.estimate_valid) begin
          report($sformatf("estimate_valid got %0b want %0b",
                           got.estimate_valid, exp_r.estimate_valid));
        end
        if (got.jitter_delay_ms !== exp_r.jitter_delay_ms) begin
          report($sformatf("jitter_delay_ms got %0d want %0d",
                           got.jitter_delay_ms, exp_r.jitter_delay_ms));
        end
        if (got.packet_interval_ms !== exp_r.packet_interval_ms) begin
          report($sformatf("packet_interval_ms got %0d want %0d",
                           got.packet_interval_ms, exp_r.packet_interval_ms));
        end
      end
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            wr_en;
  logic [rjde_pkg::CFG_IDX_W-1:0]  wr_index;
  logic [rjde_pkg::CFG_DATA_W-1:0] wr_data;
  logic                            steady;
  logic [rjde_pkg::TICKS_W-1:0]    cfg_ticks;
  int                              cfg_limit;
  int unsigned                     cycles;
  delay_scoreboard                 sb;

  rjde_in_if  pkt ();
  rjde_out_if res ();

  rtp_jitter_delay_estimator dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .packet   (pkt),
    .result   (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_rtp_jitter_delay_estimator: errors");
      $finish;
    end
  end

  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      res.ready <= steady || ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      sb.check_result({res.estimate_valid, res.jitter_delay_ms, res.packet_interval_ms});
    end
  end

  task send_packet(input logic [rjde_pkg::TS_W-1:0] rtp, input logic [rjde_pkg::TS_W-1:0] play);
    if (!steady && $urandom_range(99) < 3) begin
      repeat ($urandom_range(20, 60)) begin
        pkt.valid <= 1'b0;
        @(negedge clk);
      end
    end
    while (!steady && $urandom_range(99) < 15) begin
      pkt.valid <= 1'b0;
      @(negedge clk);
    end
    pkt.valid <= 1'b1;
    pkt.media_ts <= rtp;
    pkt.playout_ts <= play;
    do @(posedge clk); while (!pkt.ready);
    sb.note_packet(rtp, play);
    @(negedge clk);
  endtask

  task drain();
    pkt.valid <= 1'b0;
    do @(negedge clk); while (sb.pending_delays.size() != 0);
  endtask

  task write_reg(input logic [rjde_pkg::CFG_IDX_W-1:0]  idx,
                 input logic [rjde_pkg::CFG_DATA_W-1:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task apply_setting(input logic [rjde_pkg::CFG_DATA_W-1:0] ticks_data,
                     input logic [rjde_pkg::CFG_DATA_W-1:0] limit_data,
                     input logic [rjde_pkg::CFG_DATA_W-1:0] codec_data);
    drain();
    write_reg(rjde_pkg::REG_TICKS, ticks_data);
    write_reg(rjde_pkg::REG_LIMIT, limit_data);
    write_reg(rjde_pkg::REG_CODEC, codec_data);
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_ticks = ticks_data[rjde_pkg::TICKS_W-1:0];
    cfg_limit = int'(limit_data);
  endtask

  initial begin
    int          p;
    int          i;
    int          n_items;
    int          kind;
    int          sel;
    int          te;
    int          step_ms;
    int          lead_ms;
    logic [31:0] cur_rtp;
    logic [31:0] rtp;
    logic [31:0] play;

    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    pkt.valid = 1'b0;
    pkt.media_ts = '0;
    pkt.playout_ts = '0;
    steady = 1'b0;
    cfg_ticks = rjde_pkg::TICKS_RESET;
    cfg_limit = int'(rjde_pkg::LIMIT_RESET);
    sb = new();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // With no codec registered, packets leave the state alone.
    send_packet(32'd100, 32'd0);
    send_packet(32'hFFFF_FFFF, 32'h0000_0000);

    // A clock rate of zero acts as one tick per ms.
    apply_setting(16'hA500, 16'hFFFF, 16'h0003);
    send_packet(32'h0000_0000, 32'h0000_0000);
    send_packet(32'h8000_0000, 32'h0000_0000);
    send_packet(32'h0000_0000, 32'h8000_0000);
    send_packet(32'hFFFF_FFFF, 32'h0000_0000);
    send_packet(32'h0000_0000, 32'hFFFF_FFFF);
    send_packet(32'd40, 32'd40 - 32'd65535);
    send_packet(32'd80, 32'd80 - 32'd65536);
    send_packet(32'd89, 32'd84);
    send_packet(32'd150, 32'd140);
    send_packet(32'd160, 32'd150);
    send_packet(32'd220, 32'd200);

    apply_setting(16'h5AC0, 16'h0000, 16'h0001);
    send_packet(32'd220 + 32'd192 * 32'd30, 32'd0);
    send_packet(32'hFFFF_FFFF, 32'hFFFF_FF00);

    // An interval that only fits once cut to 16 bits.
    apply_setting(16'h00FF, 16'd20000, 16'h0001);
    send_packet(32'd1000000, 32'd1000000 - 32'd255 * 32'd5);
    send_packet(32'd1000000 + 32'd255 * 32'd65566, 32'd1000000 + 32'd255 * 32'd65559);
    send_packet(32'd1000000 + 32'd255 * 32'd65591, 32'd1000000 + 32'd255 * 32'd65588);

    apply_setting(16'h1208, 16'd20000, 16'hFFFE);
    send_packet(32'd12345, 32'd0);
    send_packet(32'd0, 32'd12345);

    for (p = 0; p < 8; p++) begin
      case (p)
        0: apply_setting(16'h0008, 16'd20000, 16'h0001);
        1: apply_setting({8'($urandom), 8'd1}, 16'hFFFF, {15'($urandom), 1'b1});
        2: apply_setting(16'h0030, 16'd300, 16'h0001);
        3: apply_setting({8'($urandom), 8'd192}, 16'd1000, 16'h0001);
        4: apply_setting({8'($urandom), 8'd0}, 16'($urandom), 16'h0001);
        5: apply_setting(16'h00FF, 16'd150, {15'($urandom), 1'b0});
        6: apply_setting({8'd0, 8'($urandom_range(1, 192))}, 16'hFFFF, 16'h0001);
        default: apply_setting(16'h005A, 16'd5000, 16'h0001);
      endcase
      steady = (p == 2);
      n_items = (p == 5) ? 60 : 255;
      cur_rtp = (p == 3) ? 32'hFFFF_FFFF - $urandom_range(0, 2000000) : $urandom;
      te = (cfg_ticks == 0) ? 1 : int'(cfg_ticks);
      for (i = 0; i < n_items; i++) begin
        kind = $urandom_range(99);
        if (kind < 82) begin
          step_ms = ($urandom_range(9) == 0) ? $urandom_range(0, 200) : $urandom_range(10, 60);
          cur_rtp = cur_rtp + step_ms * te + $urandom_range(0, te - 1);
          sel = $urandom_range(9);
          if (sel < 7) begin
            lead_ms = $urandom_range(1, 400);
          end else if (sel == 7) begin
            lead_ms = cfg_limit + int'($urandom_range(0, 4)) - 2;
            if (lead_ms < 0) begin
              lead_ms = 0;
            end
          end else if (sel == 8) begin
            lead_ms = 0;
          end else begin
            lead_ms = -int'($urandom_range(1, 400));
          end
          rtp = cur_rtp;
          play = cur_rtp - lead_ms * te - $urandom_range(0, te - 1);
        end else if (kind < 92) begin
          rtp = $urandom;
          play = $urandom;
          cur_rtp = rtp;
        end else begin
          rtp = cur_rtp - $urandom_range(0, 5000) * te;
          play = rtp - $urandom_range(0, 1000);
          cur_rtp = rtp;
        end
        send_packet(rtp, play);
      end
    end

    steady = 1'b0;
    drain();
    repeat (60) @(negedge clk);
    if (sb.errors == 0 && sb.pending_delays.size() == 0) begin
      $display("tb_rtp_jitter_delay_estimator: clean");
    end else begin
      $display("tb_rtp_jitter_delay_estimator: errors");
    end
    $finish;
  end

endmodule

// ===== rtp_jitter_delay_estimator.f =====
hw/rtl/rjde_pkg.sv
hw/rtl/rjde_in_if.sv
hw/rtl/rjde_out_if.sv
hw/rtl/rjde_divider.sv
hw/rtl/rjde_datapath.sv
hw/rtl/rjde_ctrl.sv
hw/rtl/rtp_jitter_delay_estimator.sv
sim/tb_rtp_jitter_delay_estimator.sv
